// File: sv/mrk_pkg.sv
// ----------------------------------------------------------------------------
// mrk_pkg: shared types and tables for the Morse relay keyer
// Beat payloads, configuration record, opcodes, status codes and code tables.
// ----------------------------------------------------------------------------
package mrk_pkg;

  localparam int unsigned CodeBitsDefault = 5;
  localparam int unsigned CfgWidth        = 12;

  localparam logic [CfgWidth-1:0] DitTicksReset = 12'd200;
  localparam logic [CfgWidth-1:0] DahTicksReset = 12'd500;
  localparam logic [CfgWidth-1:0] GapTicksReset = 12'd150;

  // register indexes on the configuration port
  localparam logic [1:0] CfgIdxDit = 2'd0;
  localparam logic [1:0] CfgIdxDah = 2'd1;
  localparam logic [1:0] CfgIdxGap = 2'd2;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SEND   = 2'd1,
    OP_ENABLE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BUSY   = 2'd1,
    ST_NOCODE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_MARK = 2'd1,
    PH_GAP  = 2'd2
  } phase_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] character;
    logic       enable_value;
  } in_item_t;

  typedef struct packed {
    logic       relay_on;
    logic       busy_res;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic [CfgWidth-1:0] dit_ticks;
    logic [CfgWidth-1:0] dah_ticks;
    logic [CfgWidth-1:0] gap_ticks;
  } cfg_t;

  // decoded character: element count and elements, right-aligned, first element in bit len-1
  typedef struct packed {
    logic       known;
    logic [2:0] len;
    logic [4:0] bits;
  } code_t;

  // {length[2:0], elements[4:0]}, 1 = dah
  localparam logic [7:0] LetterCode [26] = '{
    8'h41, 8'h88, 8'h8A, 8'h64, 8'h20, 8'h82, 8'h66, 8'h80,
    8'h40, 8'h87, 8'h65, 8'h84, 8'h43, 8'h42, 8'h67, 8'h86,
    8'h8D, 8'h62, 8'h60, 8'h21, 8'h61, 8'h81, 8'h63, 8'h89,
    8'h8B, 8'h8C
  };

  localparam logic [4:0] DigitCode [10] = '{
    5'd31, 5'd15, 5'd7, 5'd3, 5'd1, 5'd0, 5'd16, 5'd24, 5'd28, 5'd30
  };

endpackage

// File: sv/mrk_decode.sv
// ----------------------------------------------------------------------------
// mrk_decode: ASCII to Morse element lookup
// Folds lower case, then maps letters, digits, '.' and '-' to elements.
// ----------------------------------------------------------------------------
module mrk_decode (
  input  logic [7:0]     character_i,
  output mrk_pkg::code_t code_o
);
  import mrk_pkg::*;

  logic [7:0] ch_up;
  logic [7:0] letter_off;
  logic [7:0] digit_off;
  logic [7:0] letter_e;

  assign ch_up      = (character_i inside {[8'h61:8'h7A]}) ? character_i - 8'd32 : character_i;
  assign letter_off = ch_up - 8'h41;
  assign digit_off  = character_i - 8'h30;
  assign letter_e   = LetterCode[letter_off[4:0]];

  always_comb begin
    code_o = '0;
    if (ch_up inside {[8'h41:8'h5A]}) begin
      code_o.known = 1'b1;
      code_o.len   = letter_e[7:5];
      code_o.bits  = letter_e[4:0];
    end else if (character_i inside {[8'h30:8'h39]}) begin
      code_o.known = 1'b1;
      code_o.len   = 3'd5;
      code_o.bits  = DigitCode[digit_off[3:0]];
    end else if (character_i == 8'h2E || character_i == 8'h2D) begin
      code_o.known = 1'b1;
      code_o.len   = 3'd1;
      code_o.bits  = (character_i == 8'h2D) ? 5'd1 : 5'd0;
    end
  end

endmodule

// File: sv/mrk_seq.sv
// ----------------------------------------------------------------------------
// mrk_seq: keying sequencer
// Holds phase, tick count and element pattern; applies one beat per step.
// ----------------------------------------------------------------------------
module mrk_seq #(
  parameter int unsigned CODE_BITS = mrk_pkg::CodeBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  mrk_pkg::in_item_t  item_i,
  input  mrk_pkg::code_t     code_i,
  input  mrk_pkg::cfg_t      cfg_i,
  output mrk_pkg::out_item_t res_o
);
  import mrk_pkg::*;

  localparam int unsigned ShW = $clog2(CODE_BITS + 1);

  phase_e               phase_q, phase_d;
  logic                 en_q, en_d;
  logic [CODE_BITS-1:0] pattern_q, pattern_d;
  logic [2:0]           left_q, left_d;
  logic [CfgWidth-1:0]  tick_q, tick_d;
  logic [CfgWidth-1:0]  tick_inc;
  logic [CfgWidth-1:0]  mark_len;
  logic [ShW-1:0]       load_sh;
  logic                 go_start;
  status_e              status;

  assign tick_inc = tick_q + 1'b1;
  assign mark_len = pattern_q[CODE_BITS-1] ? cfg_i.dah_ticks : cfg_i.dit_ticks;
  assign load_sh  = ShW'(CODE_BITS) - ShW'(code_i.len);

  always_comb begin
    phase_d   = phase_q;
    en_d      = en_q;
    pattern_d = pattern_q;
    left_d    = left_q;
    tick_d    = tick_q;
    go_start  = 1'b0;
    status    = ST_OK;
    case (op_e'(item_i.op))
      OP_TICK: begin
        if (phase_q == PH_MARK) begin
          tick_d = tick_inc;
          if (tick_inc >= mark_len || tick_inc == '0) begin
            pattern_d = pattern_q << 1;
            left_d    = left_q - 3'd1;
            tick_d    = '0;
            if (cfg_i.gap_ticks == '0) begin
              go_start = 1'b1;
            end else begin
              phase_d = PH_GAP;
            end
          end
        end else if (phase_q == PH_GAP) begin
          tick_d = tick_inc;
          if (tick_inc >= cfg_i.gap_ticks || tick_inc == '0) begin
            go_start = 1'b1;
          end
        end
      end
      OP_SEND: begin
        if (phase_q != PH_IDLE) begin
          status = ST_BUSY;
        end else if (!code_i.known) begin
          status = ST_NOCODE;
        end else begin
          pattern_d = CODE_BITS'(code_i.bits) << load_sh;
          left_d    = code_i.len;
          go_start  = 1'b1;
        end
      end
      OP_ENABLE: en_d = item_i.enable_value;
      default: ;
    endcase
    // next element, or back to idle when done or disabled
    if (go_start) begin
      tick_d = '0;
      if (left_d == '0 || !en_q) begin
        phase_d   = PH_IDLE;
        pattern_d = '0;
        left_d    = '0;
      end else begin
        phase_d = PH_MARK;
      end
    end
  end

  always_comb begin
    res_o.relay_on = (phase_d == PH_MARK);
    res_o.busy_res = (phase_d != PH_IDLE);
    res_o.status   = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      en_q      <= 1'b0;
      pattern_q <= '0;
      left_q    <= '0;
      tick_q    <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      en_q      <= en_d;
      pattern_q <= pattern_d;
      left_q    <= left_d;
      tick_q    <= tick_d;
    end
  end

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> left_q == '0 && pattern_q == '0 && tick_q == '0)
    else $error("idle with leftover keying state");

  // the gap after the last element runs with no elements left
  a_mark_has_elem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_MARK |-> left_q != '0)
    else $error("marking with no elements left");

  a_busy_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && op_e'(item_i.op) == OP_SEND && phase_q != PH_IDLE
    |=> $stable(pattern_q) && $stable(left_q) && $stable(tick_q))
    else $error("rejected character disturbed state");

endmodule

// File: sv/morse_relay_keyer_core.sv
// ----------------------------------------------------------------------------
// morse_relay_keyer_core: Morse code keyer driving a relay
// Input register, one-pass sequencer step, result register.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid_i/in_ready_o/in_item_i): each beat is a tick, a
//   character to send, or an enable setting; every input beat yields one
//   result beat on out_valid_o/out_ready_i/out_item_o with the relay level,
//   busy flag and status after that beat.
//   cfg channel (cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i): dit, dah
//   and gap lengths in ticks; always ready, unknown indexes dropped. Write
//   only while no beat is in flight.
// Timing:
//   A beat lands in the input register; the step that runs the sequencer
//   loads the result register and raises out_valid_o, and waits while a
//   held result is not taken. Throughput is one beat per cycle while
//   out_ready_i stays high.
// Reset: both stages empty, keying disabled and idle, lengths 200/500/150.
// Backpressure: a held result stalls the sequencer step; the input register
//   still takes one beat while empty, then in_ready_o drops until it moves.
// ----------------------------------------------------------------------------
module morse_relay_keyer_core #(
  parameter int unsigned CODE_BITS = mrk_pkg::CodeBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  mrk_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output mrk_pkg::out_item_t            out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [mrk_pkg::CfgWidth-1:0]  cfg_data_i
);
  import mrk_pkg::*;

  // input stage
  logic      in_v_q;
  in_item_t  in_q;
  // result stage
  logic      out_v_q;
  out_item_t out_q;
  // configuration
  cfg_t      cfg_q;

  logic      step;     // input register beat moves into the result register
  code_t     code;
  out_item_t res;

  assign step        = in_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o  = !in_v_q || step;
  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (step) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dit_ticks <= DitTicksReset;
      cfg_q.dah_ticks <= DahTicksReset;
      cfg_q.gap_ticks <= GapTicksReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgIdxDit: cfg_q.dit_ticks <= cfg_data_i;
        CfgIdxDah: cfg_q.dah_ticks <= cfg_data_i;
        CfgIdxGap: cfg_q.gap_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mrk_decode u_decode (
    .character_i (in_q.character),
    .code_o      (code)
  );

  mrk_seq #(
    .CODE_BITS (CODE_BITS)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .code_i (code),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_v_q && !step |-> !in_ready_o)
    else $error("input register overwritten while stalled");

  a_step_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_v_q)
    else $error("stepped beat lost before result register");

  a_status_only_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && op_e'(in_q.op) != OP_SEND |-> res.status == ST_OK)
    else $error("non-send beat reported a status");

endmodule
